[design/websocket_frame_decoder_assert.svh]
// Assertion helpers for the frame decoder, sampled on the rising clock edge
// with reset held off.
`ifndef WEBSOCKET_FRAME_DECODER_ASSERT_SVH
`define WEBSOCKET_FRAME_DECODER_ASSERT_SVH

// Property holds at every edge outside reset.
`define WSFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies consequence in the next.
`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[design/wsfd_pkg.sv]
package wsfd_pkg;

  typedef enum logic [5:0] {
    PH_FIRST   = 6'b000001,
    PH_SECOND  = 6'b000010,
    PH_EXTLEN  = 6'b000100,
    PH_MASK    = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    ST_PAYLOAD   = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       final_flag;
    logic [3:0] opcode;
    status_e    status;
    logic       eof;
  } result_t;

  localparam logic [6:0] LEN16_CODE  = 7'd126;
  localparam logic [6:0] LEN64_CODE  = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [1:0] MASK_LAST   = 2'd3;

endpackage

[design/wsfd_core.sv]
module wsfd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output logic              res_valid_o,
  output wsfd_pkg::result_t res_o
);

  wsfd_pkg::phase_e phase_q, phase_d;
  logic        final_q, final_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [63:0] len_q, len_d;
  logic [3:0]  ext_q, ext_d;
  logic [31:0] word_q, word_d;
  logic [1:0]  idx_q, idx_d;
  logic [63:0] rem_q, rem_d;

  logic        empty_done;
  logic        complete;
  logic        produce;
  logic        pay_eof;
  logic [7:0]  key;
  logic [63:0] acc;
  logic [63:0] rem_dec;
  logic [3:0]  ext_dec;
  logic [6:0]  len7;

  assign len7    = byte_i[6:0];
  assign acc     = {len_q[55:0], byte_i};
  assign rem_dec = rem_q - 64'd1;
  assign ext_dec = ext_q - 4'd1;

  always_comb begin
    case (idx_q)
      2'd0:    key = word_q[31:24];
      2'd1:    key = word_q[23:16];
      2'd2:    key = word_q[15:8];
      default: key = word_q[7:0];
    endcase
    if (!masked_q) begin
      key = 8'd0;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    final_d    = final_q;
    opcode_d   = opcode_q;
    masked_d   = masked_q;
    len_d      = len_q;
    ext_d      = ext_q;
    word_d     = word_q;
    idx_d      = idx_q;
    rem_d      = rem_q;
    empty_done = 1'b0;
    complete   = 1'b0;
    produce    = 1'b0;
    pay_eof    = 1'b0;

    unique case (phase_q)
      wsfd_pkg::PH_FIRST: begin
        final_d  = byte_i[7];
        opcode_d = byte_i[3:0];
        phase_d  = wsfd_pkg::PH_SECOND;
      end
      wsfd_pkg::PH_SECOND: begin
        masked_d = byte_i[7];
        len_d    = 64'd0;
        if (len7 == wsfd_pkg::LEN16_CODE) begin
          ext_d   = wsfd_pkg::EXT16_BYTES;
          phase_d = wsfd_pkg::PH_EXTLEN;
        end else if (len7 == wsfd_pkg::LEN64_CODE) begin
          ext_d   = wsfd_pkg::EXT64_BYTES;
          phase_d = wsfd_pkg::PH_EXTLEN;
        end else begin
          rem_d = {57'd0, len7};
          idx_d = 2'd0;
          if (byte_i[7]) begin
            word_d  = 32'd0;
            phase_d = wsfd_pkg::PH_MASK;
          end else if (len7 == 7'd0) begin
            phase_d    = wsfd_pkg::PH_DONE;
            empty_done = 1'b1;
          end else begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        len_d = acc;
        ext_d = ext_dec;
        if (ext_dec == 4'd0) begin
          rem_d = acc;
          idx_d = 2'd0;
          if (masked_q) begin
            word_d  = 32'd0;
            phase_d = wsfd_pkg::PH_MASK;
          end else if (acc == 64'd0) begin
            phase_d    = wsfd_pkg::PH_DONE;
            empty_done = 1'b1;
          end else begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_MASK: begin
        word_d = {word_q[23:0], byte_i};
        idx_d  = idx_q + 2'd1;
        if (idx_q == wsfd_pkg::MASK_LAST) begin
          if (rem_q == 64'd0) begin
            phase_d    = wsfd_pkg::PH_DONE;
            empty_done = 1'b1;
          end else begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        idx_d = idx_q + 2'd1;
        rem_d = rem_dec;
        if (rem_dec == 64'd0) begin
          complete = 1'b1;
          phase_d  = wsfd_pkg::PH_DONE;
          produce  = 1'b1;
          pay_eof  = 1'b1;
        end else if (!last_i) begin
          produce = 1'b1;
        end
      end
      wsfd_pkg::PH_DONE: begin
        complete = 1'b1;
      end
      default: begin
        complete = 1'b1;
        phase_d  = wsfd_pkg::PH_FIRST;
      end
    endcase

    res_o.data       = byte_i ^ key;
    res_o.final_flag = final_d;
    res_o.opcode     = opcode_d;
    res_o.status     = wsfd_pkg::ST_PAYLOAD;
    res_o.eof        = pay_eof;

    if (empty_done) begin
      complete     = 1'b1;
      produce      = 1'b1;
      res_o.data   = 8'd0;
      res_o.status = wsfd_pkg::ST_EMPTY;
      res_o.eof    = 1'b1;
    end

    // buffer ran out before the frame did
    if (last_i) begin
      if (!complete && phase_d != wsfd_pkg::PH_DONE) begin
        produce      = 1'b1;
        res_o.data   = 8'd0;
        res_o.status = wsfd_pkg::ST_TRUNCATED;
        res_o.eof    = 1'b1;
      end
      phase_d = wsfd_pkg::PH_FIRST;
    end
  end

  assign res_valid_o = step_i && produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsfd_pkg::PH_FIRST;
      final_q  <= 1'b0;
      opcode_q <= 4'd0;
      masked_q <= 1'b0;
      len_q    <= 64'd0;
      ext_q    <= 4'd0;
      word_q   <= 32'd0;
      idx_q    <= 2'd0;
      rem_q    <= 64'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      final_q  <= final_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      ext_q    <= ext_d;
      word_q   <= word_d;
      idx_q    <= idx_d;
      rem_q    <= rem_d;
    end
  end

endmodule

[design/websocket_frame_decoder.sv]
// A byte taken into the parse stage gets its result, if any, registered in the output
// stage when the parse stage advances. Throughput: one byte per cycle unless out_stall_i
// holds the output; the parse stage's 64-bit remaining-length decrement and zero compare
// set the cycle time. Reset (rst_ni, asynchronous, active low) empties both stages and
// returns the parser to waiting for the first header byte with all header fields cleared.
module websocket_frame_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_buffer_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_out_o,
  output logic       final_flag_o,
  output logic [3:0] frame_opcode_o,
  output logic [1:0] status_o,
  output logic       end_of_frame_o
);

  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  logic              s1_last_q;
  logic              out_valid_q;
  wsfd_pkg::result_t out_q;
  wsfd_pkg::result_t res;
  logic              res_valid;
  logic              advance;
  logic              in_take;

  // parse stage moves on whenever the result register is free or draining
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= end_of_buffer_i;
    end
  end

  wsfd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (s1_byte_q),
    .last_i     (s1_last_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_out_o     = out_q.data;
  assign final_flag_o   = out_q.final_flag;
  assign frame_opcode_o = out_q.opcode;
  assign status_o       = out_q.status;
  assign end_of_frame_o = out_q.eof;

`include "websocket_frame_decoder_assert.svh"

  `WSFD_ASSERT(a_status_zero_data, !(out_valid_o && status_o != wsfd_pkg::ST_PAYLOAD) || (data_out_o == 8'd0 && end_of_frame_o), "status request carries data or lacks end of frame")
  `WSFD_ASSERT(a_stall_only_full, !in_stall_o || (s1_valid_q && out_valid_o && out_stall_i), "input stalled with room downstream")
  `WSFD_ASSERT_NEXT(a_result_lands, advance && res_valid, out_valid_o, "parsed result did not reach the output register")

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 440;

  // Models the frame parser byte by byte and holds the results still owed.
  class frame_scoreboard;
    wsfd_pkg::phase_e  phase;
    logic              fin_bit;
    logic [3:0]        opcode;
    logic              masked;
    logic [63:0]       len_acc;
    logic [3:0]        ext_left;
    logic [31:0]       key_word;
    logic [1:0]        key_idx;
    logic [63:0]       remaining;
    wsfd_pkg::result_t due_results[$];
    int unsigned       errors;

    function new();
      phase     = wsfd_pkg::PH_FIRST;
      fin_bit   = 1'b0;
      opcode    = '0;
      masked    = 1'b0;
      len_acc   = '0;
      ext_left  = '0;
      key_word  = '0;
      key_idx   = '0;
      remaining = '0;
      errors    = 0;
    endfunction

    function wsfd_pkg::result_t pack_result(logic [7:0] d, wsfd_pkg::status_e s, logic eof);
      wsfd_pkg::result_t r;
      r.data       = d;
      r.final_flag = fin_bit;
      r.opcode     = opcode;
      r.status     = s;
      r.eof        = eof;
      return r;
    endfunction

    // Length settled: mask key next, payload, or an empty frame.
    function logic length_known();
      if (masked) begin
        key_idx  = '0;
        key_word = '0;
        phase    = wsfd_pkg::PH_MASK;
        return 1'b0;
      end
      if (remaining == 0) begin
        phase = wsfd_pkg::PH_DONE;
        return 1'b1;
      end
      key_idx = '0;
      phase   = wsfd_pkg::PH_PAYLOAD;
      return 1'b0;
    endfunction

    function void decode_byte(logic [7:0] b, logic eob);
      wsfd_pkg::result_t r;
      logic              have_result;
      logic              empty_done;
      logic              complete;
      logic [7:0]        key;
      have_result = 1'b0;
      empty_done  = 1'b0;
      complete    = 1'b0;
      key         = '0;
      r           = '0;
      case (phase)
        wsfd_pkg::PH_FIRST: begin
          fin_bit = b[7];
          opcode  = b[3:0];
          phase   = wsfd_pkg::PH_SECOND;
        end
        wsfd_pkg::PH_SECOND: begin
          masked  = b[7];
          len_acc = '0;
          if (b[6:0] == wsfd_pkg::LEN16_CODE) begin
            ext_left = wsfd_pkg::EXT16_BYTES;
            phase    = wsfd_pkg::PH_EXTLEN;
          end else if (b[6:0] == wsfd_pkg::LEN64_CODE) begin
            ext_left = wsfd_pkg::EXT64_BYTES;
            phase    = wsfd_pkg::PH_EXTLEN;
          end else begin
            remaining  = {57'd0, b[6:0]};
            empty_done = length_known();
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          len_acc  = {len_acc[55:0], b};
          ext_left = ext_left - 4'd1;
          if (ext_left == 0) begin
            remaining  = len_acc;
            empty_done = length_known();
          end
        end
        wsfd_pkg::PH_MASK: begin
          key_word = {key_word[23:0], b};
          if (key_idx == wsfd_pkg::MASK_LAST) begin
            key_idx = '0;
            if (remaining == 0) begin
              phase      = wsfd_pkg::PH_DONE;
              empty_done = 1'b1;
            end else begin
              phase = wsfd_pkg::PH_PAYLOAD;
            end
          end else begin
            key_idx = key_idx + 2'd1;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          // key byte 0 is the first key byte received, held in the top of the word
          if (masked) key = key_word[8 * (3 - int'(key_idx)) +: 8];
          key_idx   = key_idx + 2'd1;
          remaining = remaining - 64'd1;
          complete  = (remaining == 0);
          if (complete) begin
            phase       = wsfd_pkg::PH_DONE;
            r           = pack_result(b ^ key, wsfd_pkg::ST_PAYLOAD, 1'b1);
            have_result = 1'b1;
          end else if (!eob) begin
            r           = pack_result(b ^ key, wsfd_pkg::ST_PAYLOAD, 1'b0);
            have_result = 1'b1;
          end
        end
        default: begin
          complete = 1'b1;
        end
      endcase
      if (empty_done) begin
        r           = pack_result(8'h00, wsfd_pkg::ST_EMPTY, 1'b1);
        have_result = 1'b1;
        complete    = 1'b1;
      end
      if (eob) begin
        if (!complete && phase != wsfd_pkg::PH_DONE) begin
          r           = pack_result(8'h00, wsfd_pkg::ST_TRUNCATED, 1'b1);
          have_result = 1'b1;
        end
        phase = wsfd_pkg::PH_FIRST;
      end
      if (have_result) due_results = {due_results, r};
    endfunction

    function void check_result(logic [7:0] d, logic f, logic [3:0] o, logic [1:0] s,
                               logic e);
      wsfd_pkg::result_t x;
      if (due_results.size() == 0) begin
        $error("unexpected result: data_out %0h status %0d", d, s);
        errors++;
        return;
      end
      x = due_results.pop_front();
      if (d !== x.data) begin
        $error("data_out: expected %0h, got %0h", x.data, d);
        errors++;
      end
      if (f !== x.final_flag) begin
        $error("final_flag: expected %0b, got %0b", x.final_flag, f);
        errors++;
      end
      if (o !== x.opcode) begin
        $error("frame_opcode: expected %0h, got %0h", x.opcode, o);
        errors++;
      end
      if (s !== x.status) begin
        $error("status: expected %0d, got %0d", x.status, s);
        errors++;
      end
      if (e !== x.eof) begin
        $error("end_of_frame: expected %0b, got %0b", x.eof, e);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i     = 8'h00;
  logic       end_of_buffer_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic [7:0] data_out_o;
  logic       final_flag_o;
  logic [3:0] frame_opcode_o;
  logic [1:0] status_o;
  logic       end_of_frame_o;

  frame_scoreboard sb;
  logic [7:0]      frame_q[$];
  int unsigned     in_gap_pct    = 0;
  int unsigned     out_stall_pct = 0;
  int unsigned     counted       = 0;
  int unsigned     cycles        = 0;

  websocket_frame_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_buffer_i(end_of_buffer_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_out_o     (data_out_o),
    .final_flag_o   (final_flag_o),
    .frame_opcode_o (frame_opcode_o),
    .status_o       (status_o),
    .end_of_frame_o (end_of_frame_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(data_out_o, final_flag_o, frame_opcode_o, status_o, end_of_frame_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void add_byte(input logic [7:0] b);
    frame_q = {frame_q, b};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob);
    @(negedge clk_i);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_buffer_i <= eob;
    do @(posedge clk_i); while (in_stall_o);
    sb.decode_byte(b, eob);
  endtask

  task automatic send_buffer();
    int i;
    for (i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed frames with random content; some noise and early cuts.
  task automatic random_buffer();
    int unsigned pick;
    int unsigned code;
    int unsigned n_payload;
    int unsigned cut;
    int          i;
    logic [63:0] declared;
    logic        msk;
    frame_q.delete();
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(5, 1)) add_byte(8'($urandom));
      counted += frame_q.size();
    end else begin
      msk  = 1'($urandom);
      code = $urandom_range(9);
      add_byte(8'($urandom));
      if (code < 6) begin
        declared = (code == 5) ? 64'($urandom_range(125)) : 64'($urandom_range(8));
        add_byte({msk, declared[6:0]});
      end else if (code < 8) begin
        declared = (code == 7) ? 64'($urandom_range(16'hFFFF)) : 64'($urandom_range(12));
        add_byte({msk, wsfd_pkg::LEN16_CODE});
        add_byte(declared[15:8]);
        add_byte(declared[7:0]);
      end else begin
        declared = (code == 9) ? {$urandom, $urandom} : 64'($urandom_range(12));
        add_byte({msk, wsfd_pkg::LEN64_CODE});
        for (i = 7; i >= 0; i--) add_byte(declared[8 * i +: 8]);
      end
      if (msk) repeat (4) add_byte(8'($urandom));
      // long frames are cut short by the buffer end
      n_payload = (declared <= 64'd125) ? int'(declared[6:0]) : $urandom_range(6);
      repeat (n_payload) add_byte(8'($urandom));
      counted += frame_q.size();
      if ($urandom_range(99) < 12) begin
        cut = $urandom_range(frame_q.size(), 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end else if (64'(n_payload) == declared) begin
        repeat ($urandom_range(3)) add_byte(8'($urandom));
      end
    end
    send_buffer();
  endtask

  task automatic run_phase(input int unsigned gap, input int unsigned stall);
    in_gap_pct    = gap;
    out_stall_pct = stall;
    counted       = 0;
    while (counted < PHASE_BYTES) random_buffer();
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // buffer of one byte: truncated, header taken from that byte
    frame_q = '{8'hFF};
    send_buffer();
    frame_q = '{8'h81, 8'h00};
    send_buffer();
    // masked empty frame
    frame_q = '{8'h02, 8'h80, 8'h00, 8'hFF, 8'h5A, 8'hA5};
    send_buffer();
    // masked payload, reserved bits set, one trailing byte
    frame_q = '{8'h7A, 8'h82, 8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'hFF, 8'hC3};
    send_buffer();
    // 64-bit length cut off mid-way
    frame_q = '{8'h80, 8'hFF, 8'hFF, 8'hFF};
    send_buffer();
    // 16-bit length, unmasked byte passes unchanged
    frame_q = '{8'h09, 8'h7E, 8'h00, 8'h01, 8'h00};
    send_buffer();
    wait_drained();

    run_phase(0, 0);
    run_phase(65, 0);
    run_phase(0, 65);
    run_phase(34, 34);

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/wsfd_pkg.sv
design/wsfd_core.sv
design/websocket_frame_decoder.sv
bench/testbench.sv
